@@ hdl/lcdws_pkg.sv @@
package lcdws_pkg;

   // Default sizes
   localparam int NUMBER_BITS_DEF = 32;
   localparam int TIMER_BITS_DEF  = 24;
   localparam int MAX_COLUMNS_DEF = 16;

   // Request kinds
   localparam logic [2:0] KIND_INIT    = 3'd0;
   localparam logic [2:0] KIND_COMMAND = 3'd1;
   localparam logic [2:0] KIND_CHAR    = 3'd2;
   localparam logic [2:0] KIND_CURSOR  = 3'd3;
   localparam logic [2:0] KIND_NUMBER  = 3'd4;

   // Control register indexes
   localparam logic [1:0] CSR_ENABLE_HIGH = 2'd0;
   localparam logic [1:0] CSR_ENABLE_LOW  = 2'd1;
   localparam logic [1:0] CSR_INIT_GAP    = 2'd2;
   localparam logic [1:0] CSR_CLEAR_GAP   = 2'd3;

   // Control register reset values
   localparam int RESET_ENABLE_HIGH = 100000;
   localparam int RESET_ENABLE_LOW  = 100000;
   localparam int RESET_INIT_GAP    = 50000;
   localparam int RESET_CLEAR_GAP   = 100000;

   // Display codes
   localparam logic [7:0] LINE1_BASE  = 8'h80;
   localparam logic [7:0] LINE2_BASE  = 8'hC0;
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ROW_LINE1   = 8'd1;
   localparam logic [7:0] ROW_LINE2   = 8'd2;
   localparam logic [7:0] ROW_LIMIT   = 8'd3;
   localparam logic [1:0] INIT_STEP_CLEAR = 2'd2;
   localparam logic [1:0] INIT_STEP_FINAL = 2'd3;

   // One result item
   typedef struct packed {
      logic       write_valid;
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       error;
      logic       last;
   } rsp_type;

   // Power-up command sequence: function set, display on, clear, entry mode
   function automatic logic [7:0] init_cmd(input logic [1:0] step);
      logic [7:0] code;
      unique case (step)
         2'd0:    code = 8'h38;
         2'd1:    code = 8'h0C;
         2'd2:    code = 8'h01;
         default: code = 8'h06;
      endcase
      return code;
   endfunction

   // Decimal place weights, highest place fits in 32 bits
   function automatic logic [31:0] pow10(input logic [3:0] place);
      logic [31:0] weight;
      unique case (place)
         4'd0:    weight = 32'd1;
         4'd1:    weight = 32'd10;
         4'd2:    weight = 32'd100;
         4'd3:    weight = 32'd1000;
         4'd4:    weight = 32'd10000;
         4'd5:    weight = 32'd100000;
         4'd6:    weight = 32'd1000000;
         4'd7:    weight = 32'd10000000;
         4'd8:    weight = 32'd100000000;
         4'd9:    weight = 32'd1000000000;
         default: weight = 32'd0;
      endcase
      return weight;
   endfunction

   // Decimal digits needed for the largest value of a given width
   function automatic int digits_for(input int bits);
      longint unsigned value;
      int count;
      value = (64'd1 << bits) - 64'd1;
      count = 0;
      for (int i = 0; i < 20; i++) begin
         if (value != 0) begin
            value = value / 10;
            count = count + 1;
         end
      end
      return count;
   endfunction

endpackage

@@ hdl/char_lcd_write_sequencer.sv @@
// Each display write counts down the enable-high time, then the enable-low time, then, for
// setup writes only, a gap wait, before its result is offered on the result port.
// Number requests extract each decimal place by repeated subtraction before its write.
// One request is in progress at a time; the next transfer is taken once the last result leaves.
// Reset (synchronous, active high) restores the timing registers and idles the sequencer.
module char_lcd_write_sequencer #(
   parameter int NUMBER_BITS = lcdws_pkg::NUMBER_BITS_DEF,
   parameter int TIMER_BITS  = lcdws_pkg::TIMER_BITS_DEF,
   parameter int MAX_COLUMNS = lcdws_pkg::MAX_COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // byte_value, column, row, number
   input  logic [((24+NUMBER_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bus_byte
   output logic [7:0]                          rsp_tdata,
   // write_valid, reg_select, error
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [TIMER_BITS-1:0]               csr_data
);

   import lcdws_pkg::*;

   logic [TIMER_BITS-1:0] enable_high_ff, enable_high_in;
   logic [TIMER_BITS-1:0] enable_low_ff, enable_low_in;
   logic [TIMER_BITS-1:0] init_gap_ff, init_gap_in;
   logic [TIMER_BITS-1:0] clear_gap_ff, clear_gap_in;
   rsp_type               rsp_item;

   // Timing registers: take every transfer on the control port
   assign csr_ready = 1'b1;

   always_comb begin
      enable_high_in = enable_high_ff;
      enable_low_in  = enable_low_ff;
      init_gap_in    = init_gap_ff;
      clear_gap_in   = clear_gap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE_HIGH: enable_high_in = csr_data;
            CSR_ENABLE_LOW:  enable_low_in  = csr_data;
            CSR_INIT_GAP:    init_gap_in    = csr_data;
            CSR_CLEAR_GAP:   clear_gap_in   = csr_data;
            default:         enable_high_in = enable_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_high_ff <= TIMER_BITS'(RESET_ENABLE_HIGH);
         enable_low_ff  <= TIMER_BITS'(RESET_ENABLE_LOW);
         init_gap_ff    <= TIMER_BITS'(RESET_INIT_GAP);
         clear_gap_ff   <= TIMER_BITS'(RESET_CLEAR_GAP);
      end else begin
         enable_high_ff <= enable_high_in;
         enable_low_ff  <= enable_low_in;
         init_gap_ff    <= init_gap_in;
         clear_gap_ff   <= clear_gap_in;
      end
   end

   // Write sequencer with its shared subtractor
   lcdws_seq #(
      .NUMBER_BITS(NUMBER_BITS),
      .TIMER_BITS (TIMER_BITS),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_kind         (req_tuser),
      .req_byte         (req_tdata[7:0]),
      .req_column       (req_tdata[15:8]),
      .req_row          (req_tdata[23:16]),
      .req_number       (req_tdata[24+NUMBER_BITS-1:24]),
      .enable_high_ticks(enable_high_ff),
      .enable_low_ticks (enable_low_ff),
      .init_gap_ticks   (init_gap_ff),
      .clear_gap_ticks  (clear_gap_ff),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_item         (rsp_item)
   );

   assign rsp_tdata = rsp_item.bus_byte;
   assign rsp_tuser = {rsp_item.error, rsp_item.reg_select, rsp_item.write_valid};
   assign rsp_tlast = rsp_item.last;

`ifndef SYNTHESIS
   a_ready_excludes_result: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_no_write_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0 && !rsp_tuser[1])
      else $error("result without a write carries bus data");

   a_error_ends_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && !rsp_tuser[0])
      else $error("error result is not a lone final result");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready after final result transfer");
`endif

endmodule

@@ hdl/lcdws_alu.sv @@
module lcdws_alu #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] alu_a,
   input  logic [WIDTH-1:0] alu_b,
   output logic [WIDTH-1:0] alu_diff,
   output logic             alu_borrow
);

   // Shared subtractor: borrow means a is below b
   assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};

endmodule

@@ hdl/lcdws_seq.sv @@
module lcdws_seq #(
   parameter int NUMBER_BITS = 32,
   parameter int TIMER_BITS  = 24,
   parameter int MAX_COLUMNS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_kind,
   input  logic [7:0]             req_byte,
   input  logic [7:0]             req_column,
   input  logic [7:0]             req_row,
   input  logic [NUMBER_BITS-1:0] req_number,
   input  logic [TIMER_BITS-1:0]  enable_high_ticks,
   input  logic [TIMER_BITS-1:0]  enable_low_ticks,
   input  logic [TIMER_BITS-1:0]  init_gap_ticks,
   input  logic [TIMER_BITS-1:0]  clear_gap_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lcdws_pkg::rsp_type     rsp_item
);

   import lcdws_pkg::*;

   localparam int UNIT_BITS = (NUMBER_BITS > TIMER_BITS) ? NUMBER_BITS : TIMER_BITS;
   localparam int DIGITS    = digits_for(NUMBER_BITS);
   localparam int IDX_BITS  = $clog2(DIGITS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIGIT = 3'd1;
   localparam logic [2:0] ST_HIGH  = 3'd2;
   localparam logic [2:0] ST_LOW   = 3'd3;
   localparam logic [2:0] ST_GAP   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [2:0]             kind_ff, kind_in;
   logic [TIMER_BITS-1:0]  tick_timer_ff, tick_timer_in;
   logic [NUMBER_BITS-1:0] remainder_ff, remainder_in;
   logic [IDX_BITS-1:0]    digit_index_ff, digit_index_in;
   logic [3:0]             digit_count_ff, digit_count_in;
   logic                   started_ff, started_in;
   logic [1:0]             init_step_ff, init_step_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_select_ff, held_select_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_write_ff, rsp_write_in;
   logic                   rsp_error_ff, rsp_error_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [UNIT_BITS-1:0]   alu_a, alu_b, alu_diff;
   logic                   alu_borrow;
   logic                   timer_done;
   logic                   write_last;

   // One subtractor serves both the tick countdown and the digit extraction
   lcdws_alu #(
      .WIDTH(UNIT_BITS)
   ) u_alu (
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_diff  (alu_diff),
      .alu_borrow(alu_borrow)
   );

   // Steer operands: remainder against place weight, else timer against one
   always_comb begin
      if (state_ff == ST_DIGIT) begin
         alu_a = UNIT_BITS'(remainder_ff);
         alu_b = UNIT_BITS'(pow10(4'(digit_index_ff)));
      end else begin
         alu_a = UNIT_BITS'(tick_timer_ff);
         alu_b = UNIT_BITS'(1);
      end
   end

   // A count of zero or one ends the wait
   assign timer_done = alu_borrow || (alu_diff == '0);

   // Final write of the request
   always_comb begin
      if (kind_ff == KIND_INIT) begin
         write_last = (init_step_ff == INIT_STEP_FINAL);
      end else if (kind_ff == KIND_NUMBER) begin
         write_last = (digit_index_ff == '0);
      end else begin
         write_last = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      tick_timer_in  = tick_timer_ff;
      remainder_in   = remainder_ff;
      digit_index_in = digit_index_ff;
      digit_count_in = digit_count_ff;
      started_in     = started_ff;
      init_step_in   = init_step_ff;
      held_byte_in   = held_byte_ff;
      held_select_in = held_select_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_write_in   = rsp_write_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               tick_timer_in = enable_high_ticks;
               unique case (req_kind)
                  KIND_INIT: begin
                     init_step_in   = 2'd0;
                     held_byte_in   = init_cmd(2'd0);
                     held_select_in = 1'b0;
                     state_in       = ST_HIGH;
                  end
                  KIND_COMMAND: begin
                     held_byte_in   = req_byte;
                     held_select_in = 1'b0;
                     state_in       = ST_HIGH;
                  end
                  KIND_CHAR: begin
                     held_byte_in   = req_byte;
                     held_select_in = 1'b1;
                     state_in       = ST_HIGH;
                  end
                  KIND_CURSOR: begin
                     priority if (req_column >= 8'(MAX_COLUMNS) || req_row >= ROW_LIMIT) begin
                        // out of range: flag and write nothing
                        rsp_valid_in = 1'b1;
                        rsp_write_in = 1'b0;
                        rsp_error_in = 1'b1;
                        rsp_last_in  = 1'b1;
                        state_in     = ST_EMIT;
                     end else if (req_row == ROW_LINE1) begin
                        held_byte_in   = LINE1_BASE + req_column;
                        held_select_in = 1'b0;
                        state_in       = ST_HIGH;
                     end else if (req_row == ROW_LINE2) begin
                        held_byte_in   = LINE2_BASE + req_column;
                        held_select_in = 1'b0;
                        state_in       = ST_HIGH;
                     end else begin
                        // row zero selects no line
                        rsp_valid_in = 1'b1;
                        rsp_write_in = 1'b0;
                        rsp_error_in = 1'b0;
                        rsp_last_in  = 1'b1;
                        state_in     = ST_EMIT;
                     end
                  end
                  KIND_NUMBER: begin
                     remainder_in   = req_number;
                     digit_index_in = IDX_BITS'(DIGITS - 1);
                     digit_count_in = 4'd0;
                     started_in     = 1'b0;
                     state_in       = ST_DIGIT;
                  end
                  default: begin
                     // unknown kind: drop it
                  end
               endcase
            end
         end

         ST_DIGIT: begin
            if (!alu_borrow) begin
               // subtract one place weight and count it
               remainder_in   = alu_diff[NUMBER_BITS-1:0];
               digit_count_in = digit_count_ff + 4'd1;
            end else if (digit_count_ff != 4'd0 || started_ff || digit_index_ff == '0) begin
               started_in     = 1'b1;
               held_byte_in   = ASCII_ZERO + {4'd0, digit_count_ff};
               held_select_in = 1'b1;
               tick_timer_in  = enable_high_ticks;
               state_in       = ST_HIGH;
            end else begin
               // skip a leading zero
               digit_index_in = digit_index_ff - IDX_BITS'(1);
            end
         end

         ST_HIGH: begin
            if (timer_done) begin
               tick_timer_in = enable_low_ticks;
               state_in      = ST_LOW;
            end else begin
               tick_timer_in = alu_diff[TIMER_BITS-1:0];
            end
         end

         ST_LOW: begin
            if (!timer_done) begin
               tick_timer_in = alu_diff[TIMER_BITS-1:0];
            end else if (kind_ff == KIND_INIT) begin
               tick_timer_in = (init_step_ff == INIT_STEP_CLEAR) ? clear_gap_ticks
                                                                  : init_gap_ticks;
               state_in      = ST_GAP;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_write_in = 1'b1;
               rsp_error_in = 1'b0;
               rsp_last_in  = write_last;
               state_in     = ST_EMIT;
            end
         end

         ST_GAP: begin
            if (timer_done) begin
               rsp_valid_in = 1'b1;
               rsp_write_in = 1'b1;
               rsp_error_in = 1'b0;
               rsp_last_in  = write_last;
               state_in     = ST_EMIT;
            end else begin
               tick_timer_in = alu_diff[TIMER_BITS-1:0];
            end
         end

         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == KIND_INIT) begin
                  // advance to the next setup command
                  init_step_in   = init_step_ff + 2'd1;
                  held_byte_in   = init_cmd(init_step_ff + 2'd1);
                  held_select_in = 1'b0;
                  tick_timer_in  = enable_high_ticks;
                  state_in       = ST_HIGH;
               end else begin
                  // next lower decimal place
                  digit_index_in = digit_index_ff - IDX_BITS'(1);
                  digit_count_in = 4'd0;
                  state_in       = ST_DIGIT;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         kind_ff        <= KIND_INIT;
         tick_timer_ff  <= '0;
         remainder_ff   <= '0;
         digit_index_ff <= '0;
         digit_count_ff <= 4'd0;
         started_ff     <= 1'b0;
         init_step_ff   <= 2'd0;
         held_byte_ff   <= 8'd0;
         held_select_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_write_ff   <= 1'b0;
         rsp_error_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         tick_timer_ff  <= tick_timer_in;
         remainder_ff   <= remainder_in;
         digit_index_ff <= digit_index_in;
         digit_count_ff <= digit_count_in;
         started_ff     <= started_in;
         init_step_ff   <= init_step_in;
         held_byte_ff   <= held_byte_in;
         held_select_ff <= held_select_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_write_ff   <= rsp_write_in;
         rsp_error_ff   <= rsp_error_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   // Outputs: a result without a write shows zero byte and select
   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item.write_valid = rsp_write_ff;
   assign rsp_item.reg_select  = rsp_write_ff & held_select_ff;
   assign rsp_item.bus_byte    = rsp_write_ff ? held_byte_ff : 8'd0;
   assign rsp_item.error       = rsp_error_ff;
   assign rsp_item.last        = rsp_last_ff;

endmodule

@@ tb/sv/char_lcd_write_sequencer_tb.sv @@
`timescale 1ns / 100ps

module char_lcd_write_sequencer_tb;
   import lcdws_pkg::*;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          SETTLE_CAP     = 1000;
   localparam logic [23:0] TIMER_MAX      = 24'hFF_FFFF;

   // Power-up command bytes
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [31:0] number;
   } lcd_req_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // byte_value, column, row, number
   logic [55:0] req_tdata  = '0;
   // kind
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // bus_byte
   logic [7:0]  rsp_tdata;
   // write_valid, reg_select, error
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [23:0] csr_data   = '0;

   lcd_req_type pending_reqs[$];
   rsp_type     expected_writes[$];
   lcd_req_type req_cur;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned quiet_cycles;
   int unsigned error_count;
   logic        no_idle = 1'b0;

   // Local copy of the timing registers
   logic [23:0] lcd_timing[4];

   char_lcd_write_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none at all during quiet stretches
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) begin
         no_idle <= ~no_idle;
      end
   end

   function automatic void expect_write(input logic rs, input logic [7:0] value,
                                        input logic is_last);
      rsp_type w;
      w.write_valid = 1'b1;
      w.reg_select  = rs;
      w.bus_byte    = value;
      w.error       = 1'b0;
      w.last        = is_last;
      expected_writes.push_back(w);
   endfunction

   // Work out the bus writes one request causes
   function automatic void predict_writes(input lcd_req_type r);
      rsp_type     no_write;
      logic [7:0]  digits[10];
      logic [31:0] rest;
      int          count;
      case (r.kind)
         KIND_INIT: begin
            expect_write(1'b0, LCD_FUNCTION_SET, 1'b0);
            expect_write(1'b0, LCD_DISPLAY_ON, 1'b0);
            expect_write(1'b0, LCD_CLEAR, 1'b0);
            expect_write(1'b0, LCD_ENTRY_MODE, 1'b1);
         end
         KIND_COMMAND: expect_write(1'b0, r.byte_value, 1'b1);
         KIND_CHAR:    expect_write(1'b1, r.byte_value, 1'b1);
         KIND_CURSOR: begin
            if (r.column < MAX_COLUMNS_DEF && r.row < ROW_LIMIT && r.row == ROW_LINE1) begin
               expect_write(1'b0, LINE1_BASE + r.column, 1'b1);
            end else if (r.column < MAX_COLUMNS_DEF && r.row == ROW_LINE2) begin
               expect_write(1'b0, LINE2_BASE + r.column, 1'b1);
            end else begin
               // Row zero writes nothing; anything out of range flags an error
               no_write             = '0;
               no_write.error       = !(r.column < MAX_COLUMNS_DEF && r.row < ROW_LIMIT);
               no_write.last        = 1'b1;
               expected_writes.push_back(no_write);
            end
         end
         KIND_NUMBER: begin
            rest  = r.number;
            count = 0;
            do begin
               digits[count] = 8'(rest % 10);
               rest          = rest / 10;
               count++;
            end while (rest != 0);
            for (int i = count - 1; i >= 0; i--) begin
               expect_write(1'b1, ASCII_ZERO + digits[i], i == 0);
            end
         end
         default: ;
      endcase
   endfunction

   // Present queued requests, predicting each one as it transfers
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_writes(req_cur);
         end
         if (req_gap != 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_cur     = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= req_cur.kind;
            req_tdata  <= {req_cur.number, req_cur.row, req_cur.column, req_cur.byte_value};
            req_gap    <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side at random and check every write against the oldest expectation
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_valid = rsp_tuser[0];
            got.reg_select  = rsp_tuser[1];
            got.bus_byte    = rsp_tdata;
            got.error       = rsp_tuser[2];
            got.last        = rsp_tlast;
            if (expected_writes.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected write: wv=%0d rs=%0d byte=%02h err=%0d last=%0d",
                           got.write_valid, got.reg_select, got.bus_byte, got.error,
                           got.last);
            end else begin
               want = expected_writes.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("write mismatch: expected wv=%0d rs=%0d byte=%02h err=%0d last=%0d",
                            want.write_valid, want.reg_select, want.bus_byte, want.error,
                            want.last);
                     $display(", got wv=%0d rs=%0d byte=%02h err=%0d last=%0d",
                              got.write_valid, got.reg_select, got.bus_byte, got.error,
                              got.last);
                  end
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= pick_gap();
         end
      end
   end

   // Abort when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("char_lcd_write_sequencer_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      lcd_timing[index] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [23:0] high_ticks, input logic [23:0] low_ticks,
                             input logic [23:0] init_gap, input logic [23:0] clear_gap);
      write_reg(CSR_ENABLE_HIGH, high_ticks);
      write_reg(CSR_ENABLE_LOW, low_ticks);
      write_reg(CSR_INIT_GAP, init_gap);
      write_reg(CSR_CLEAR_GAP, clear_gap);
   endtask

   // Wait for every write to land, then wait a settle time taken from the timing registers
   task automatic drain_writes();
      int settle;
      while (pending_reqs.size() != 0 || req_tvalid || expected_writes.size() != 0)
         @(negedge clock);
      settle = 32;
      foreach (lcd_timing[i])
         settle += (lcd_timing[i] == 0) ? 1 : int'(lcd_timing[i]);
      if (settle > SETTLE_CAP)
         settle = SETTLE_CAP;
      repeat (settle) @(posedge clock);
   endtask

   function automatic lcd_req_type make_req(input logic [2:0] kind, input logic [7:0] value,
                                            input logic [7:0] column, input logic [7:0] row,
                                            input logic [31:0] number);
      lcd_req_type r;
      r.kind       = kind;
      r.byte_value = value;
      r.column     = column;
      r.row        = row;
      r.number     = number;
      return r;
   endfunction

   // Random content in every field; the kind decides which fields matter
   function automatic lcd_req_type random_req();
      lcd_req_type r;
      int unsigned roll;
      roll         = $urandom_range(0, 99);
      r.byte_value = 8'($urandom);
      r.column     = 8'($urandom);
      r.row        = 8'($urandom);
      r.number     = $urandom;
      if (roll < 6) begin
         r.kind = KIND_INIT;
      end else if (roll < 25) begin
         r.kind = KIND_COMMAND;
      end else if (roll < 45) begin
         r.kind = KIND_CHAR;
      end else if (roll < 70) begin
         r.kind = KIND_CURSOR;
         if ($urandom_range(0, 3) != 0) begin
            r.column = 8'($urandom_range(0, MAX_COLUMNS_DEF - 1));
            r.row    = 8'($urandom_range(0, ROW_LIMIT - 1));
         end
      end else if (roll < 95) begin
         r.kind   = KIND_NUMBER;
         r.number = $urandom >> $urandom_range(0, 31);
      end else begin
         r.kind = KIND_NUMBER + 3'($urandom_range(1, 3));
      end
      return r;
   endfunction

   task automatic queue_random(input int amount);
      lcd_req_type r;
      int          counted;
      counted = 0;
      @(negedge clock);
      while (counted < amount) begin
         r = random_req();
         pending_reqs.push_back(r);
         if (r.kind <= KIND_NUMBER)
            counted++;
      end
   endtask

   initial begin
      lcd_timing[CSR_ENABLE_HIGH] = 24'(RESET_ENABLE_HIGH);
      lcd_timing[CSR_ENABLE_LOW]  = 24'(RESET_ENABLE_LOW);
      lcd_timing[CSR_INIT_GAP]    = 24'(RESET_INIT_GAP);
      lcd_timing[CSR_CLEAR_GAP]   = 24'(RESET_CLEAR_GAP);
      error_count                 = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Shortest timing, then the directed requests
      set_timing(24'd1, 24'd1, 24'd0, 24'd0);
      @(negedge clock);
      pending_reqs.push_back(make_req(KIND_INIT, 8'h00, 8'h00, 8'h00, 32'd0));
      pending_reqs.push_back(make_req(KIND_COMMAND, 8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(KIND_COMMAND, 8'hFF, 8'h00, 8'h00, 32'd0));
      pending_reqs.push_back(make_req(KIND_CHAR, 8'h00, 8'h00, 8'h00, 32'd0));
      pending_reqs.push_back(make_req(KIND_CHAR, 8'hFF, 8'h00, 8'h00, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd0, ROW_LINE1, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd15, ROW_LINE1, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd0, ROW_LINE2, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd15, ROW_LINE2, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd5, 8'd0, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd16, ROW_LINE1, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'd0, ROW_LIMIT, 32'd0));
      pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 8'hFF, 8'hFF, 32'd0));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'd0));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'd9));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'd10));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'd999_999_999));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'd1_000_000_000));
      pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(KIND_NUMBER + 3'd1, 8'h12, 8'h00, 8'h01, 32'd5));
      pending_reqs.push_back(make_req(KIND_NUMBER + 3'd3, 8'h34, 8'h02, 8'h01, 32'd7));
      pending_reqs.push_back(make_req(KIND_INIT, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      drain_writes();

      // Zero enable times, which the countdown ends like a count of one
      set_timing(24'd0, 24'd0, 24'($urandom_range(1, 20)), 24'($urandom_range(1, 20)));
      queue_random(26);
      drain_writes();

      // Take every register to its top value, then back down to short random timing
      set_timing(TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX);
      set_timing(24'($urandom_range(2, 16)), 24'($urandom_range(2, 16)),
                 24'($urandom_range(0, 40)), 24'($urandom_range(0, 40)));
      queue_random(26);
      drain_writes();

      set_timing(24'($urandom_range(1, 6)), 24'($urandom_range(1, 6)),
                 24'($urandom_range(0, 8)), 24'($urandom_range(0, 8)));
      queue_random(26);
      drain_writes();

      if (error_count == 0 && expected_writes.size() == 0) begin
         $display("char_lcd_write_sequencer_tb: done, clean");
      end else begin
         $display("char_lcd_write_sequencer_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/lcdws_pkg.sv
hdl/lcdws_alu.sv
hdl/lcdws_seq.sv
hdl/char_lcd_write_sequencer.sv
tb/sv/char_lcd_write_sequencer_tb.sv
